/* rtl/bve_pkg.sv */
// Shared request and status codes for the bounded vector engine.
package bve_pkg;

    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [OP_W-1:0]          op_t;
    typedef logic [ST_W-1:0]          status_t;

    localparam op_t OP_PUSH   = 3'd0;
    localparam op_t OP_POP    = 3'd1;
    localparam op_t OP_GET    = 3'd2;
    localparam op_t OP_INSERT = 3'd3;
    localparam op_t OP_REMOVE = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

/* rtl/bve_ram.sv */
// Single write port, single read port word store with registered read data.
module bve_ram
    import bve_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  word_t         wdata,
    input  logic [AW-1:0] raddr,
    output word_t         rdata
);

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bounded_vector_engine.sv */
// Bounded vector engine: ordered word list with push, pop, get, insert and remove.
// Push, insert at the end and failed requests finish straight from idle; pop and
// get return the word from S_READ; remove returns it from S_RMH and shifts later
// words down in S_RMS; other inserts shift up in S_INS, then write in S_PUT.
// Throughput is set by the single RAM port pair: one word moved per cycle.
// Reset clears the count and control state; the store is not cleared. done cannot stall.
module bounded_vector_engine
    import bve_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  op_t                           op,
    input  logic [$clog2(DEPTH+1)-1:0]    position,
    input  word_t                         word_in,
    output logic                          done,
    output status_t                       status,
    output word_t                         word_out,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_RMH  = 3'd2;
    localparam logic [2:0] S_RMS  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          done_reg, done_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] pos_reg, pos_next;
    word_t         word_reg, word_next;
    status_t       status_reg, status_next;
    word_t         word_out_reg, word_out_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    word_t         ram_rdata;

    bve_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        done_next     = 1'b0;
        cur_next      = cur_reg;
        pos_next      = pos_reg;
        word_next     = word_reg;
        status_next   = status_reg;
        word_out_next = word_out_reg;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // default: finish at once with an out-of-range result
                    done_next     = 1'b1;
                    status_next   = ST_RANGE;
                    word_out_next = '0;
                    case (op)
                        OP_PUSH:
                        begin
                            if (fill_reg >= CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = AW'(fill_reg);
                                ram_wdata   = word_in;
                                fill_next   = fill_reg + CW'(1);
                                status_next = ST_OK;
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_reg != '0)
                            begin
                                done_next  = 1'b0;
                                ram_raddr  = AW'(fill_reg - CW'(1));
                                fill_next  = fill_reg - CW'(1);
                                state_next = S_READ;
                            end
                        end
                        OP_GET:
                        begin
                            if (position < fill_reg)
                            begin
                                done_next  = 1'b0;
                                ram_raddr  = AW'(position);
                                state_next = S_READ;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (position > fill_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (fill_reg >= CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (position == fill_reg)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = AW'(position);
                                ram_wdata   = word_in;
                                fill_next   = fill_reg + CW'(1);
                                status_next = ST_OK;
                            end
                            else
                            begin
                                // shift up from the top, one word per cycle
                                done_next  = 1'b0;
                                ram_raddr  = AW'(fill_reg - CW'(1));
                                cur_next   = AW'(fill_reg);
                                pos_next   = AW'(position);
                                word_next  = word_in;
                                fill_next  = fill_reg + CW'(1);
                                state_next = S_INS;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (position < fill_reg)
                            begin
                                done_next  = 1'b0;
                                ram_raddr  = AW'(position);
                                cur_next   = AW'(position);
                                fill_next  = fill_reg - CW'(1);
                                state_next = S_RMH;
                            end
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next     = 1'b1;
                status_next   = ST_OK;
                word_out_next = ram_rdata;
                state_next    = S_IDLE;
            end
            S_RMH:
            begin
                word_out_next = ram_rdata;
                status_next   = ST_OK;
                // fill_reg already holds the new count
                if (CW'(cur_reg) < fill_reg)
                begin
                    ram_raddr  = cur_reg + AW'(1);
                    state_next = S_RMS;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RMS:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = ram_rdata;
                if (CW'(cur_reg) + CW'(1) < fill_reg)
                begin
                    ram_raddr = cur_reg + AW'(2);
                    cur_next  = cur_reg + AW'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = ram_rdata;
                if (cur_reg - AW'(1) > pos_reg)
                begin
                    ram_raddr = cur_reg - AW'(2);
                    cur_next  = cur_reg - AW'(1);
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                ram_we        = 1'b1;
                ram_waddr     = pos_reg;
                ram_wdata     = word_reg;
                done_next     = 1'b1;
                status_next   = ST_OK;
                word_out_next = '0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        word_reg     <= word_next;
        status_reg   <= status_next;
        word_out_reg <= word_out_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign word_out = word_out_reg;
    assign count    = fill_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a transaction is still in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("count exceeds capacity");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || state_reg != S_IDLE))
        else $error("accepted transaction neither finished nor started work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg == ST_OK || status_reg == ST_RANGE
                      || status_reg == ST_FULL))
        else $error("undefined status code on result");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(fill_reg))
        else $error("count changed during a multi-cycle transaction");
`endif

endmodule
